// ===== rtl/core/lbp_pkg.sv =====
package lbp_pkg;

  // Field widths
  localparam int POS_W    = 11;
  localparam int ANCHOR_W = 10;
  localparam int LBL_W_W  = 9;
  localparam int LBL_H_W  = 6;
  localparam int OFF_W    = 7;
  localparam int CMP_W    = 13;
  localparam int FIX_W    = 4;

  // Search constants
  localparam int NUM_FIXED     = 10;
  localparam int STACK_START   = 6;
  localparam int STACK_LIMIT   = 60;
  localparam int STACK_GAP     = 2;
  localparam int FALLBACK_DY   = 4;
  localparam int MAX_BOXES_DEF = 64;

  // Operation codes (in_tuser)
  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_PLACE = 1'b1;

  // Offset direction of one fixed candidate, per axis
  typedef enum logic [1:0] {
    DIR_ZERO  = 2'd0,
    DIR_PLUS  = 2'd1,
    DIR_MINUS = 2'd2
  } dir_t;

  // A stored label box
  typedef struct packed {
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [LBL_W_W-1:0] w;
    logic [LBL_H_W-1:0] h;
  } box_t;

  // Candidate beat handed from cell to cell
  typedef struct packed {
    logic             vld;
    logic             last;
    logic             clash;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
  } cand_t;

  // Horizontal direction of fixed candidate k
  function automatic dir_t fixed_dx(input logic [FIX_W-1:0] k);
    dir_t d;
    case (k)
      4'd4, 4'd5, 4'd6: d = DIR_PLUS;
      4'd7, 4'd8, 4'd9: d = DIR_MINUS;
      default:          d = DIR_ZERO;
    endcase
    return d;
  endfunction

  // Vertical direction of fixed candidate k (the down-shift is tried twice)
  function automatic dir_t fixed_dy(input logic [FIX_W-1:0] k);
    dir_t d;
    case (k)
      4'd1, 4'd5, 4'd8:       d = DIR_MINUS;
      4'd2, 4'd3, 4'd6, 4'd9: d = DIR_PLUS;
      default:                d = DIR_ZERO;
    endcase
    return d;
  endfunction

  // Sign extension of a position to the compare width
  function automatic logic signed [CMP_W-1:0] sext_pos(input logic [POS_W-1:0] v);
    return signed'({{(CMP_W-POS_W){v[POS_W-1]}}, v});
  endfunction

endpackage

// ===== rtl/core/lbp_cell.sv =====
module lbp_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en_i,
  input  logic                          wr_i,
  input  lbp_pkg::box_t                 wr_box_i,
  input  logic [lbp_pkg::LBL_W_W-1:0]   cand_w_i,
  input  logic [lbp_pkg::LBL_H_W-1:0]   cand_h_i,
  input  lbp_pkg::cand_t                beat_i,
  output lbp_pkg::cand_t                beat_o
);

  lbp_pkg::box_t  box_r;
  lbp_pkg::cand_t beat_r;

  logic signed [lbp_pkg::CMP_W-1:0] cx, cy, cw, ch;
  logic signed [lbp_pkg::CMP_W-1:0] bx, by, bw, bh;
  logic                             hit;

  // Open-interval overlap of the passing candidate with the held box
  always_comb begin
    cx  = lbp_pkg::sext_pos(beat_i.x);
    cy  = lbp_pkg::sext_pos(beat_i.y);
    cw  = signed'(lbp_pkg::CMP_W'(cand_w_i));
    ch  = signed'(lbp_pkg::CMP_W'(cand_h_i));
    bx  = lbp_pkg::sext_pos(box_r.x);
    by  = lbp_pkg::sext_pos(box_r.y);
    bw  = signed'(lbp_pkg::CMP_W'(box_r.w));
    bh  = signed'(lbp_pkg::CMP_W'(box_r.h));
    hit = en_i && !((cx + cw <= bx) || (bx + bw <= cx) ||
                    (cy + ch <= by) || (by + bh <= cy));
  end

  // Box storage, loaded when this cell's slot is written
  always_ff @(posedge clk) begin
    if (wr_i) begin
      box_r <= wr_box_i;
    end
  end

  // Pass the candidate on to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.vld <= 1'b0;
    end else begin
      beat_r.vld <= beat_i.vld;
    end
    beat_r.last  <= beat_i.last;
    beat_r.clash <= beat_i.clash | hit;
    beat_r.x     <= beat_i.x;
    beat_r.y     <= beat_i.y;
  end

  assign beat_o = beat_r;

endmodule

// ===== rtl/core/label_box_placer_top.sv =====
// Greedy label placer. A beat with in_tuser = 0 empties the box table and
// returns one all-zero result. A beat with in_tuser = 1
// tries ten fixed offsets around the anchor, then a downward stack at
// x = anchor_x - w/2, and returns the first candidate that overlaps no
// stored box (storing it while room is left), or the fallback position.
// Candidates are issued one per cycle into a chain of MAX_BOXES cells, one
// box per cell, and checked as they travel down it; a place beat issues the
// ten fixed candidates and S = ceil(54 / (h + 2)) stack candidates. One item
// is worked on at a time; the next is taken while a result still waits.
module label_box_placer_top #(
  parameter int MAX_BOXES = lbp_pkg::MAX_BOXES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [9:0] anchor_x, [19:10] anchor_y, [28:20] label_width,
  // [34:29] label_height, [39:35] zero
  input  logic [39:0] in_tdata,
  // [0] operation
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [10:0] pos_x, [21:11] pos_y, [23:22] zero
  output logic [23:0] out_tdata,
  // [0] recorded, [1] table_full
  output logic [1:0]  out_tuser
);

  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam int POS_W = lbp_pkg::POS_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_ISSUE  = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [lbp_pkg::ANCHOR_W-1:0] ax_r, ay_r;
  logic [lbp_pkg::LBL_W_W-1:0]  w_r;
  logic [lbp_pkg::LBL_H_W-1:0]  h_r;
  logic                         clr_r;
  logic [lbp_pkg::FIX_W-1:0]    k_r;
  logic [lbp_pkg::OFF_W-1:0]    off_r, off_sum;
  logic [CNT_W-1:0]             count_r;
  logic                         found_r;
  logic [POS_W-1:0]             fx_r, fy_r;

  logic             out_vld_r;
  logic [POS_W-1:0] out_x_r, out_y_r;
  logic             out_rec_r, out_full_r;

  logic             in_acc, res_fire, room;
  logic [POS_W-1:0] ax11, ay11, w11, h11, half11, off11;
  lbp_pkg::dir_t    dx, dy;
  lbp_pkg::cand_t   issue;
  lbp_pkg::box_t    new_box;
  lbp_pkg::cand_t   chain [MAX_BOXES+1];
  lbp_pkg::cand_t   tail;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign res_fire  = (state_r == S_RESULT) && (!out_vld_r || out_tready);
  assign room      = (count_r < CNT_W'(MAX_BOXES));
  assign tail      = chain[MAX_BOXES];

  // Candidate generation
  always_comb begin
    ax11    = POS_W'(signed'(ax_r));
    ay11    = POS_W'(signed'(ay_r));
    w11     = POS_W'(w_r);
    h11     = POS_W'(h_r);
    half11  = POS_W'(w_r >> 1);
    off11   = POS_W'(off_r);
    off_sum = off_r + lbp_pkg::OFF_W'(h_r) + lbp_pkg::OFF_W'(lbp_pkg::STACK_GAP);
    dx      = lbp_pkg::fixed_dx(k_r);
    dy      = lbp_pkg::fixed_dy(k_r);

    issue       = '0;
    issue.vld   = (state_r == S_ISSUE);
    if (k_r < lbp_pkg::FIX_W'(lbp_pkg::NUM_FIXED)) begin
      case (dx)
        lbp_pkg::DIR_PLUS:  issue.x = ax11 + w11;
        lbp_pkg::DIR_MINUS: issue.x = ax11 - w11;
        default:            issue.x = ax11;
      endcase
      case (dy)
        lbp_pkg::DIR_PLUS:  issue.y = ay11 + h11;
        lbp_pkg::DIR_MINUS: issue.y = ay11 - h11;
        default:            issue.y = ay11;
      endcase
    end else begin
      issue.x    = ax11 - half11;
      issue.y    = ay11 + off11;
      issue.last = (off_sum >= lbp_pkg::OFF_W'(lbp_pkg::STACK_LIMIT));
    end
  end

  assign chain[0] = issue;

  // Box to store
  always_comb begin
    new_box.x = fx_r;
    new_box.y = fy_r;
    new_box.w = w_r;
    new_box.h = h_r;
  end

  // Cell chain, one stored box per cell
  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    lbp_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en_i     (CNT_W'(i) < count_r),
      .wr_i     (res_fire && !clr_r && found_r && room && (count_r == CNT_W'(i))),
      .wr_box_i (new_box),
      .cand_w_i (w_r),
      .cand_h_i (h_r),
      .beat_i   (chain[i]),
      .beat_o   (chain[i+1])
    );
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_tuser == lbp_pkg::OP_CLEAR) ? S_RESULT : S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (issue.last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (tail.vld && tail.last) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (res_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Item capture and candidate counters
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ax_r  <= in_tdata[9:0];
      ay_r  <= in_tdata[19:10];
      w_r   <= in_tdata[28:20];
      h_r   <= in_tdata[34:29];
      clr_r <= (in_tuser == lbp_pkg::OP_CLEAR);
      k_r   <= '0;
      off_r <= lbp_pkg::OFF_W'(lbp_pkg::STACK_START);
    end else if (state_r == S_ISSUE) begin
      if (k_r < lbp_pkg::FIX_W'(lbp_pkg::NUM_FIXED)) begin
        k_r <= k_r + 1'b1;
      end else begin
        off_r <= off_sum;
      end
    end
  end

  // First free candidate out of the chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (in_acc) begin
      found_r <= 1'b0;
    end else if (tail.vld && !tail.clash && !found_r) begin
      found_r <= 1'b1;
    end
    if (tail.vld && !tail.clash && !found_r) begin
      fx_r <= tail.x;
      fy_r <= tail.y;
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (in_acc && (in_tuser == lbp_pkg::OP_CLEAR)) begin
      count_r <= '0;
    end else if (res_fire && !clr_r && found_r && room) begin
      count_r <= count_r + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_fire) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
    if (res_fire) begin
      if (clr_r) begin
        out_x_r    <= '0;
        out_y_r    <= '0;
        out_rec_r  <= 1'b0;
        out_full_r <= 1'b0;
      end else if (found_r) begin
        out_x_r    <= fx_r;
        out_y_r    <= fy_r;
        out_rec_r  <= room;
        out_full_r <= !room;
      end else begin
        out_x_r    <= ax11 - half11;
        out_y_r    <= ay11 + POS_W'(lbp_pkg::FALLBACK_DY);
        out_rec_r  <= 1'b0;
        out_full_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_y_r, out_x_r};
  assign out_tuser  = {out_full_r, out_rec_r};

endmodule

// ===== tb/label_box_placer_top_tb.sv =====
`timescale 1ns / 1ps

module label_box_placer_top_tb;

  localparam real CLK_PERIOD   = 12.0;
  localparam int  RESET_CYCLES = 12;
  localparam int  RANDOM_ITEMS = 1000;
  // a place beat issues at most 10 + 27 candidates into the cell chain
  localparam int  DRAIN_CYCLES = 160;
  localparam int  LIMIT_CYCLES = 800000;

  // One expected result
  typedef struct packed {
    logic [lbp_pkg::POS_W-1:0] pos_x;
    logic [lbp_pkg::POS_W-1:0] pos_y;
    logic                      recorded;
    logic                      table_full;
  } spot_t;

  // Mirror of the placed-box table plus the queue of spots still to come out
  class label_layout_board;
    int    box_x[lbp_pkg::MAX_BOXES_DEF];
    int    box_y[lbp_pkg::MAX_BOXES_DEF];
    int    box_w[lbp_pkg::MAX_BOXES_DEF];
    int    box_h[lbp_pkg::MAX_BOXES_DEF];
    int    n_boxes;
    int    errors;
    spot_t expected_spots[$];
    // multipliers of w and h for the fixed candidates
    int    col_mult[lbp_pkg::NUM_FIXED] = '{0, 0, 0, 0, 1, 1, 1, -1, -1, -1};
    int    row_mult[lbp_pkg::NUM_FIXED] = '{0, -1, 1, 1, 0, -1, 1, 0, -1, 1};

    function new();
      n_boxes = 0;
      errors  = 0;
    endfunction

    // strict open-interval test against every stored box
    function bit spot_is_free(int cx, int cy, int w, int h);
      for (int i = 0; i < n_boxes; i++) begin
        if (!(cx + w <= box_x[i] || box_x[i] + box_w[i] <= cx ||
              cy + h <= box_y[i] || box_y[i] + box_h[i] <= cy))
          return 1'b0;
      end
      return 1'b1;
    endfunction

    // greedy search: fixed offsets, then the downward stack, else fallback
    function spot_t choose_spot(logic op, logic [39:0] d);
      spot_t r;
      int    ax, ay, w, h, cx, cy, off;
      bit    found;
      r     = '0;
      found = 1'b0;
      cx    = 0;
      cy    = 0;
      if (op == lbp_pkg::OP_CLEAR) begin
        n_boxes = 0;
        return r;
      end
      ax = int'($signed(d[9:0]));
      ay = int'($signed(d[19:10]));
      w  = int'(d[28:20]);
      h  = int'(d[34:29]);
      for (int k = 0; k < lbp_pkg::NUM_FIXED && !found; k++) begin
        cx    = ax + col_mult[k] * w;
        cy    = ay + row_mult[k] * h;
        found = spot_is_free(cx, cy, w, h);
      end
      for (off = lbp_pkg::STACK_START; off < lbp_pkg::STACK_LIMIT && !found;
           off += h + lbp_pkg::STACK_GAP) begin
        cx    = ax - w / 2;
        cy    = ay + off;
        found = spot_is_free(cx, cy, w, h);
      end
      if (found) begin
        if (n_boxes < lbp_pkg::MAX_BOXES_DEF) begin
          box_x[n_boxes] = cx;
          box_y[n_boxes] = cy;
          box_w[n_boxes] = w;
          box_h[n_boxes] = h;
          n_boxes++;
          r.recorded = 1'b1;
        end else begin
          r.table_full = 1'b1;
        end
      end else begin
        cx = ax - w / 2;
        cy = ay + lbp_pkg::FALLBACK_DY;
      end
      r.pos_x = cx[lbp_pkg::POS_W-1:0];
      r.pos_y = cy[lbp_pkg::POS_W-1:0];
      return r;
    endfunction

    function void take_request(logic op, logic [39:0] d);
      expected_spots.insert(expected_spots.size(), choose_spot(op, d));
    endfunction

    function void match_result(logic [23:0] d, logic [1:0] u);
      spot_t e;
      if (expected_spots.size() == 0) begin
        $error("result beat with nothing pending: pos_x %0d pos_y %0d",
               $signed(d[10:0]), $signed(d[21:11]));
        errors++;
        return;
      end
      e = expected_spots.pop_front();
      if (d[10:0] !== e.pos_x) begin
        $error("pos_x: expected %0d, got %0d", $signed(e.pos_x), $signed(d[10:0]));
        errors++;
      end
      if (d[21:11] !== e.pos_y) begin
        $error("pos_y: expected %0d, got %0d", $signed(e.pos_y), $signed(d[21:11]));
        errors++;
      end
      if (u[0] !== e.recorded) begin
        $error("recorded: expected %0b, got %0b", e.recorded, u[0]);
        errors++;
      end
      if (u[1] !== e.table_full) begin
        $error("table_full: expected %0b, got %0b", e.table_full, u[1]);
        errors++;
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic        in_tuser   = lbp_pkg::OP_CLEAR;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;

  int idle_pct  = 0;
  int stall_pct = 0;

  label_layout_board board = new();

  label_box_placer_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #(CLK_PERIOD / 2.0) clk = ~clk;

  // Run limit
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: check accepted beats, stall at random
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        board.match_result(out_tdata, out_tuser);
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one beat, optionally after an idle gap; valid stays high for the next
  task automatic send_beat(input logic op, input int ax, input int ay,
                           input int w, input int h);
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'b0, h[5:0], w[8:0], ay[9:0], ax[9:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.take_request(op, in_tdata);
  endtask

  // Stimulus
  initial begin
    int sent;
    int n_place;
    int mode;
    int cx;
    int cy;
    int phase;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // same label again and again: every fixed offset, the stack, then fallback
    send_beat(lbp_pkg::OP_CLEAR, 0, 0, 0, 0);
    repeat (13) send_beat(lbp_pkg::OP_PLACE, 0, 0, 100, 20);
    // field extremes, zero sizes, over-wide label
    send_beat(lbp_pkg::OP_PLACE, -512, -512, 511, 63);
    send_beat(lbp_pkg::OP_PLACE, 511, 511, 511, 63);
    send_beat(lbp_pkg::OP_PLACE, -512, 511, 0, 0);
    send_beat(lbp_pkg::OP_PLACE, 511, -512, 320, 1);
    send_beat(lbp_pkg::OP_PLACE, 0, 0, 0, 0);
    send_beat(lbp_pkg::OP_PLACE, 5, 5, 1, 0);
    send_beat(lbp_pkg::OP_CLEAR, -1, -1, 511, 63);

    // random bursts of place beats, mostly opened by a clear
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase = (sent * 4) / RANDOM_ITEMS;
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 79; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 79; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      if ($urandom_range(9) != 0) begin
        send_beat(lbp_pkg::OP_CLEAR, $urandom_range(1023), $urandom_range(1023),
                  $urandom_range(511), $urandom_range(63));
        sent++;
      end
      n_place = $urandom_range(1, 90);
      mode    = $urandom_range(2);
      cx      = $urandom_range(800) - 400;
      cy      = $urandom_range(800) - 400;
      repeat (n_place) begin
        if ($urandom_range(99) < 3) begin
          // stray clear in the middle of a burst
          send_beat(lbp_pkg::OP_CLEAR, $urandom_range(1023), $urandom_range(1023),
                    $urandom_range(511), $urandom_range(63));
        end else begin
          case (mode)
            // crowded patch: lots of clashes, stack and fallback
            0: send_beat(lbp_pkg::OP_PLACE, cx + $urandom_range(80) - 40,
                         cy + $urandom_range(80) - 40,
                         $urandom_range(80), $urandom_range(24));
            // anywhere, any size
            1: send_beat(lbp_pkg::OP_PLACE, $urandom_range(1023) - 512,
                         $urandom_range(1023) - 512,
                         $urandom_range(511), $urandom_range(63));
            // spread out, flat labels: fills the table
            default: send_beat(lbp_pkg::OP_PLACE, $urandom_range(1023) - 512,
                               $urandom_range(1023) - 512,
                               $urandom_range(60), $urandom_range(12));
          endcase
        end
        sent++;
      end
    end

    // drain
    in_tvalid <= 1'b0;
    while (board.expected_spots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
